>>> hdl/lemf_pkg.sv
// shared types for the line endpoint medoid fit block
// controller state encoding and the command and status bundles between
// controller and datapath; no dependencies
`default_nettype none

package lemf_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PIVOT,
        ST_SWEEP,
        ST_DRAIN,
        ST_RESULT
    } lemf_state_t;

    typedef struct packed {
        logic load_en;      // item offered while loading
        logic rd_en;        // read both stores at rd_addr
        logic rd_pivot;     // this read fetches the candidate value
        logic clear_acc;    // start a new sum
        logic compare;      // sums are final, compare against best
        logic first;        // first candidate of the set
        logic load_result;  // write the output register
        logic clear_count;  // empty the set
    } lemf_cmd_t;

    typedef struct packed {
        logic count_zero;   // no segment stored
        logic pipe_busy;    // samples still in the sum pipeline
        logic out_free;     // output register can take a result
    } lemf_status_t;

endpackage

`default_nettype wire

>>> hdl/lemf_datapath.sv
// datapath of the line endpoint medoid fit: row stores, squared distance
// pipeline, sum accumulators, best tracking and output register
// depends on lemf_pkg
`default_nettype none

module lemf_datapath
    import lemf_pkg::*;
#(
    parameter int MAX_LINES = 256,
    parameter int ROW_BITS  = 12,
    parameter int AW        = 8,
    parameter int CW        = 9
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire lemf_cmd_t           cmd,
    input  wire logic [AW-1:0]       rd_addr,
    input  wire logic [ROW_BITS-1:0] left_row,
    input  wire logic [ROW_BITS-1:0] right_row,
    input  wire logic                has_line,
    input  wire logic                out_ready,
    output lemf_status_t             status,
    output logic [AW-1:0]            last_idx,
    output logic                     out_valid,
    output logic [ROW_BITS-1:0]      left_fit,
    output logic [ROW_BITS-1:0]      right_fit,
    output logic                     found
);

    localparam int SQW = 2 * ROW_BITS;
    localparam int SW  = SQW + CW;

    logic [ROW_BITS-1:0] left_mem  [MAX_LINES];
    logic [ROW_BITS-1:0] right_mem [MAX_LINES];

    logic [CW-1:0]       count_reg, count_next;
    logic                full;

    logic [ROW_BITS-1:0] left_rd_reg, right_rd_reg;
    logic [ROW_BITS-1:0] left_piv_reg, right_piv_reg;
    logic                pivot_flag_reg, s1_valid_reg, s2_valid_reg;
    logic [ROW_BITS-1:0] left_diff, right_diff;
    logic [SQW-1:0]      left_sq_reg, right_sq_reg;
    logic [SW-1:0]       left_acc_reg, right_acc_reg;
    logic [SW-1:0]       left_best_sum_reg, right_best_sum_reg;
    logic [ROW_BITS-1:0] left_best_reg, right_best_reg;
    logic                out_valid_reg;
    logic [ROW_BITS-1:0] left_fit_reg, right_fit_reg;
    logic                found_reg;
    logic                store_en;

    assign full     = (count_reg == CW'(MAX_LINES));
    assign store_en = cmd.load_en && has_line && !full;
    assign last_idx = AW'(count_reg - CW'(1));

    always_comb begin
        count_next = count_reg;
        if (cmd.clear_count) begin
            count_next = '0;
        end else if (store_en) begin
            count_next = count_reg + CW'(1);
        end
    end

    // stores, written in fill order
    always_ff @(posedge aclk) begin
        if (store_en) begin
            left_mem[count_reg[AW-1:0]]  <= left_row;
            right_mem[count_reg[AW-1:0]] <= right_row;
        end
        if (cmd.rd_en) begin
            left_rd_reg  <= left_mem[rd_addr];
            right_rd_reg <= right_mem[rd_addr];
        end
    end

    assign left_diff  = (left_piv_reg >= left_rd_reg) ? left_piv_reg - left_rd_reg
                                                     : left_rd_reg - left_piv_reg;
    assign right_diff = (right_piv_reg >= right_rd_reg) ? right_piv_reg - right_rd_reg
                                                        : right_rd_reg - right_piv_reg;

    always_ff @(posedge aclk) begin
        if (pivot_flag_reg) begin
            left_piv_reg  <= left_rd_reg;
            right_piv_reg <= right_rd_reg;
        end
        left_sq_reg  <= SQW'(left_diff) * SQW'(left_diff);
        right_sq_reg <= SQW'(right_diff) * SQW'(right_diff);

        if (cmd.clear_acc) begin
            left_acc_reg  <= '0;
            right_acc_reg <= '0;
        end else if (s2_valid_reg) begin
            left_acc_reg  <= left_acc_reg + SW'(left_sq_reg);
            right_acc_reg <= right_acc_reg + SW'(right_sq_reg);
        end

        // strict less-than keeps the earliest entry on a tie
        if (cmd.compare && (cmd.first || left_acc_reg < left_best_sum_reg)) begin
            left_best_sum_reg <= left_acc_reg;
            left_best_reg     <= left_piv_reg;
        end
        if (cmd.compare && (cmd.first || right_acc_reg < right_best_sum_reg)) begin
            right_best_sum_reg <= right_acc_reg;
            right_best_reg     <= right_piv_reg;
        end

        if (cmd.load_result) begin
            found_reg     <= !status.count_zero;
            left_fit_reg  <= status.count_zero ? '0 : left_best_reg;
            right_fit_reg <= status.count_zero ? '0 : right_best_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg      <= '0;
            pivot_flag_reg <= 1'b0;
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            count_reg      <= count_next;
            pivot_flag_reg <= cmd.rd_en && cmd.rd_pivot;
            s1_valid_reg   <= cmd.rd_en && !cmd.rd_pivot;
            s2_valid_reg   <= s1_valid_reg;
            if (cmd.load_result) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.count_zero = (count_reg == '0);
    assign status.pipe_busy  = s1_valid_reg || s2_valid_reg;
    assign status.out_free   = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign left_fit  = left_fit_reg;
    assign right_fit = right_fit_reg;
    assign found     = found_reg;

    a_compare_after_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.compare |-> !(s1_valid_reg || s2_valid_reg))
        else $error("sum compared while samples still in flight");

    a_no_result_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_result |-> (!out_valid_reg || out_ready))
        else $error("result written over a result not yet taken");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(MAX_LINES))
        else $error("segment count beyond store depth");

    a_empty_result: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_result && status.count_zero |=> !found_reg && left_fit_reg == '0)
        else $error("empty set must give a cleared result");

endmodule

`default_nettype wire

>>> hdl/lemf_ctrl.sv
// controller of the line endpoint medoid fit: loading, the candidate and
// sweep loops of the fit, and result hand-off
// depends on lemf_pkg
`default_nettype none

module lemf_ctrl
    import lemf_pkg::*;
#(
    parameter int AW = 8
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    input  wire logic          s_last,
    output logic               s_ready,
    input  wire lemf_status_t  status,
    input  wire logic [AW-1:0] last_idx,
    output lemf_cmd_t          cmd,
    output logic [AW-1:0]      rd_addr
);

    lemf_state_t   state_reg, state_next;
    logic [AW-1:0] i_reg, i_next;
    logic [AW-1:0] j_reg, j_next;

    // next state and loop counters
    always_comb begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        case (state_reg)
            ST_IDLE: begin
                i_next = '0;
                if (s_valid && s_last) begin
                    state_next = ST_PIVOT;
                end
            end
            ST_PIVOT: begin
                j_next = '0;
                state_next = status.count_zero ? ST_RESULT : ST_SWEEP;
            end
            ST_SWEEP: begin
                j_next = j_reg + AW'(1);
                if (j_reg == last_idx) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!status.pipe_busy) begin
                    if (i_reg == last_idx) begin
                        state_next = ST_RESULT;
                    end else begin
                        i_next     = i_reg + AW'(1);
                        state_next = ST_PIVOT;
                    end
                end
            end
            ST_RESULT: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // commands
    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        rd_addr = j_reg;
        case (state_reg)
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.load_en = s_valid;
            end
            ST_PIVOT: begin
                cmd.rd_en     = !status.count_zero;
                cmd.rd_pivot  = 1'b1;
                cmd.clear_acc = 1'b1;
                rd_addr       = i_reg;
            end
            ST_SWEEP: begin
                cmd.rd_en = 1'b1;
            end
            ST_DRAIN: begin
                cmd.compare = !status.pipe_busy;
                cmd.first   = (i_reg == '0);
            end
            ST_RESULT: begin
                cmd.load_result = status.out_free;
                cmd.clear_count = status.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
        end else begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
        end
    end

    a_sweep_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SWEEP) |-> (j_reg <= last_idx) && (i_reg <= last_idx))
        else $error("fit address beyond stored entries");

    a_sweep_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SWEEP) |-> !status.count_zero)
        else $error("sweep started on an empty set");

endmodule

`default_nettype wire

>>> hdl/line_endpoint_medoid_fit.sv
// loading: one item per cycle; after the item with tlast the fit reads both row stores
// through one shared read port, one sample per cycle during each sweep, and an empty
// set goes straight to the result
// throughput: one item per cycle while loading, no items taken during the fit
// reset: aresetn synchronous active low empties the set and clears the output valid;
// store contents are not cleared, only entries below the count are read
`default_nettype none

module line_endpoint_medoid_fit
    import lemf_pkg::*;
#(
    parameter int MAX_LINES = 256,
    parameter int ROW_BITS  = 12
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    // segment items
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    input  wire logic [((2*ROW_BITS+7)/8)*8-1:0]      s_tdata,  // left_row, right_row, zero pad
    input  wire logic                                 s_tuser,  // has_line
    input  wire logic                                 s_tlast,  // is_last
    // fit results
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    output logic [((2*ROW_BITS+7)/8)*8-1:0]           m_tdata,  // left_fit, right_fit, zero pad
    output logic                                      m_tuser   // found
);

    localparam int TDW = ((2*ROW_BITS+7)/8)*8;
    localparam int AW  = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
    localparam int CW  = $clog2(MAX_LINES + 1);

    lemf_cmd_t           cmd;
    lemf_status_t        status;
    logic [AW-1:0]       rd_addr;
    logic [AW-1:0]       last_idx;
    logic [ROW_BITS-1:0] left_fit, right_fit;

    // sequencer: load phase, then per candidate a pivot read, a sweep over
    // all entries and a drain of the two stage sum pipeline
    lemf_ctrl #(
        .AW (AW)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_tvalid),
        .s_last   (s_tlast),
        .s_ready  (s_tready),
        .status   (status),
        .last_idx (last_idx),
        .cmd      (cmd),
        .rd_addr  (rd_addr)
    );

    // stores, squared distance sums and the output register
    lemf_datapath #(
        .MAX_LINES (MAX_LINES),
        .ROW_BITS  (ROW_BITS),
        .AW        (AW),
        .CW        (CW)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .rd_addr   (rd_addr),
        .left_row  (s_tdata[ROW_BITS-1:0]),
        .right_row (s_tdata[2*ROW_BITS-1:ROW_BITS]),
        .has_line  (s_tuser),
        .out_ready (m_tready),
        .status    (status),
        .last_idx  (last_idx),
        .out_valid (m_tvalid),
        .left_fit  (left_fit),
        .right_fit (right_fit),
        .found     (m_tuser)
    );

    // pack the result, pad bits stay zero
    assign m_tdata = TDW'({right_fit, left_fit});

endmodule

`default_nettype wire
